// ----- design/swrl_pkg.sv -----
package swrl_pkg;

  localparam int unsigned NumAppsDef     = 4;
  localparam int unsigned RingEntriesDef = 16;
  localparam int unsigned MaxApps        = 4;

  localparam logic [31:0] WindowReset = 32'd1000000;
  localparam logic [47:0] SumMax      = 48'hFFFF_FFFF_FFFF;

  typedef enum logic [1:0] {
    OpRecord = 2'd0,
    OpCheck  = 2'd1,
    OpClear  = 2'd2,
    OpNone   = 2'd3
  } op_e;

  // Register indexes on the configuration port.
  localparam logic [2:0] RegWindow = 3'd0;
  localparam logic [2:0] RegEnable = 3'd1;
  localparam logic [2:0] RegLimit0 = 3'd2;
  localparam logic [2:0] RegLimit1 = 3'd3;
  localparam logic [2:0] RegLimit2 = 3'd4;
  localparam logic [2:0] RegLimit3 = 3'd5;

  // Classified command handed from the front part to the back part.
  typedef struct packed {
    op_e         op;
    logic [1:0]  app;
    logic        has_limit;
    logic        limit_zero;
    logic [31:0] now;
    logic [32:0] amount;
    logic [31:0] request;
  } cmd_t;

  typedef enum logic [2:0] {
    StIdle,
    StRead,
    StPrune,
    StDecide,
    StOut
  } back_state_e;

  typedef struct packed {
    logic        allowed;
    logic [47:0] window_sum;
    logic        entry_dropped;
  } result_t;

endpackage

// ----- design/sliding_window_rate_limiter.sv -----
// Sliding-window-log rate limiter for up to four applications.
// Input transactions arrive on the s_axis group: record (log bytes against
// an application's window), check (ask whether request_bytes fits under the
// limit after expired entries are dropped) and clear (empty every window).
// Each input transaction yields exactly one output transaction on m_axis:
// allowed, the live window sum for checks, and a flag when a record pushed
// the oldest entry out of a full ring.
// The front part classifies an item and queues it in a two-deep queue; the
// back part owns the ring memory and works one item at a time, through the
// states read and out, with a decide state between them for a record into
// a full ring and a prune state for a check that has a nonzero limit.
// Pruning reads one ring entry per cycle from the single memory read port.
// After reset all windows are empty and the registers hold their reset
// values; the ring memory needs no clearing pass. When the receiver stalls
// the result waits in the output register and the queue keeps accepting
// until it is full. Configuration goes through the APB port; the user
// must write it only while idle, as the block itself does not enforce it.
module sliding_window_rate_limiter #(
  parameter int unsigned NumApps     = swrl_pkg::NumAppsDef,
  parameter int unsigned RingEntries = swrl_pkg::RingEntriesDef
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // tdata: operation[1:0], app_index[3:2], now_ticks[35:4],
  // bytes_sent[67:36], bytes_received[99:68], request_bytes[131:100]
  input  logic [135:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // tdata: allowed[0], window_sum[48:1], entry_dropped[49]
  output logic [55:0]  m_axis_tdata,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [5:0]   paddr,
  input  logic [63:0]  pwdata,
  output logic [63:0]  prdata,
  output logic         pready
);
  import swrl_pkg::*;

  logic [31:0]     window_q;
  logic [3:0]      enable_q;
  logic [4*40-1:0] limits_q;
  logic            cfg_wr;
  logic [2:0]      reg_idx;

  cmd_t    cmd;
  logic    cmd_valid, cmd_ready;
  result_t res;

  assign pready  = 1'b1;
  assign reg_idx = paddr[5:3];
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q <= WindowReset;
      enable_q <= '0;
      limits_q <= '0;
    end else if (cfg_wr) begin
      case (reg_idx)
        RegWindow: window_q <= pwdata[31:0];
        RegEnable: enable_q <= pwdata[3:0];
        RegLimit0: limits_q[0*40 +: 40] <= pwdata[39:0];
        RegLimit1: limits_q[1*40 +: 40] <= pwdata[39:0];
        RegLimit2: limits_q[2*40 +: 40] <= pwdata[39:0];
        RegLimit3: limits_q[3*40 +: 40] <= pwdata[39:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      RegWindow: prdata = {32'd0, window_q};
      RegEnable: prdata = {60'd0, enable_q};
      RegLimit0: prdata = {24'd0, limits_q[0*40 +: 40]};
      RegLimit1: prdata = {24'd0, limits_q[1*40 +: 40]};
      RegLimit2: prdata = {24'd0, limits_q[2*40 +: 40]};
      RegLimit3: prdata = {24'd0, limits_q[3*40 +: 40]};
      default:   prdata = '0;
    endcase
  end

  swrl_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .op_i        (s_axis_tdata[1:0]),
    .app_i       (s_axis_tdata[3:2]),
    .now_i       (s_axis_tdata[35:4]),
    .sent_i      (s_axis_tdata[67:36]),
    .recv_i      (s_axis_tdata[99:68]),
    .req_i       (s_axis_tdata[131:100]),
    .enable_i    (enable_q),
    .limits_i    (limits_q),
    .num_apps_i  (3'(NumApps)),
    .cmd_valid_o (cmd_valid),
    .cmd_ready_i (cmd_ready),
    .cmd_o       (cmd)
  );

  swrl_back #(
    .RingEntries (RingEntries)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_ready_o (cmd_ready),
    .cmd_i       (cmd),
    .window_i    (window_q),
    .limits_i    (limits_q),
    .res_valid_o (m_axis_tvalid),
    .res_ready_i (m_axis_tready),
    .res_o       (res)
  );

  assign m_axis_tdata = {6'd0, res.entry_dropped, res.window_sum, res.allowed};
endmodule

// ----- design/swrl_front.sv -----
module swrl_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [1:0]           op_i,
  input  logic [1:0]           app_i,
  input  logic [31:0]          now_i,
  input  logic [31:0]          sent_i,
  input  logic [31:0]          recv_i,
  input  logic [31:0]          req_i,
  input  logic [3:0]           enable_i,
  input  logic [4*40-1:0]      limits_i,
  input  logic [2:0]           num_apps_i,
  output logic                 cmd_valid_o,
  input  logic                 cmd_ready_i,
  output swrl_pkg::cmd_t       cmd_o
);
  import swrl_pkg::*;

  // Two-entry queue toward the back part.
  cmd_t       fifo_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;
  cmd_t       cls;
  logic       push, pop;
  logic [39:0] lim;

  always_comb begin
    lim            = limits_i[app_i*40 +: 40];
    cls.op         = op_e'(op_i);
    cls.app        = app_i;
    cls.has_limit  = ({1'b0, app_i} < num_apps_i) && enable_i[app_i];
    cls.limit_zero = (lim == 40'd0);
    cls.now        = now_i;
    cls.amount     = {1'b0, sent_i} + {1'b0, recv_i};
    cls.request    = req_i;
  end

  assign in_ready_o  = (cnt_q != 2'd2);
  assign push        = in_valid_i && in_ready_o;
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign pop         = cmd_valid_o && cmd_ready_i;
  assign cmd_o       = fifo_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= cls;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (pop)  rd_ptr_q <= ~rd_ptr_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule

// ----- design/swrl_back.sv -----
module swrl_back #(
  parameter int unsigned RingEntries = swrl_pkg::RingEntriesDef
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cmd_valid_i,
  output logic                 cmd_ready_o,
  input  swrl_pkg::cmd_t       cmd_i,
  input  logic [31:0]          window_i,
  input  logic [4*40-1:0]      limits_i,
  output logic                 res_valid_o,
  input  logic                 res_ready_i,
  output swrl_pkg::result_t    res_o
);
  import swrl_pkg::*;

  localparam int unsigned IdxW   = (RingEntries > 1) ? $clog2(RingEntries) : 1;
  localparam int unsigned CntW   = $clog2(RingEntries + 1);
  localparam int unsigned AppW   = 2;
  localparam int unsigned Depth  = MaxApps * (1 << IdxW);
  localparam int unsigned AddrW  = AppW + IdxW;

  logic [31:0] time_mem [Depth];
  logic [32:0] amt_mem  [Depth];
  logic [31:0] rd_time_q;
  logic [32:0] rd_amt_q;

  logic [IdxW-1:0] head_q [MaxApps];
  logic [CntW-1:0] count_q [MaxApps];
  logic [47:0]     sum_q [MaxApps];

  back_state_e state_q, state_d;
  cmd_t        cmd_q;
  result_t     res_q, res_d;
  logic        res_valid_q;

  logic [1:0]      a;
  logic [IdxW-1:0] head;
  logic [IdxW-1:0] head_inc;
  logic [CntW-1:0] cnt;
  logic [47:0]     sum;
  logic            full;
  logic [IdxW-1:0] wpos;
  logic [AddrW-1:0] rd_addr;
  logic            rd_en, wr_en, do_pop, do_push, do_clear, take;
  logic [47:0]     sum_after_pop, sum_after_push;
  logic [48:0]     tot;
  logic [31:0]     age;
  logic [CntW:0]   wpos_wide;

  assign a    = cmd_q.app;
  assign head = head_q[a];
  assign cnt  = count_q[a];
  assign sum  = sum_q[a];
  assign full = (cnt == CntW'(RingEntries));
  assign head_inc  = (head == IdxW'(RingEntries - 1)) ? '0 : head + 1'b1;
  assign wpos_wide = (CntW+1)'(head) + (CntW+1)'(cnt);
  assign wpos = (wpos_wide >= (CntW+1)'(RingEntries)) ?
                IdxW'(wpos_wide - (CntW+1)'(RingEntries)) : wpos_wide[IdxW-1:0];
  assign age  = cmd_q.now - rd_time_q;
  assign sum_after_pop  = (sum >= {15'd0, rd_amt_q}) ? sum - {15'd0, rd_amt_q} : 48'd0;
  assign tot  = {1'b0, sum} + {16'd0, cmd_q.request};

  logic [48:0] push_src, push_tot;
  always_comb begin
    push_src = full ? {1'b0, sum_after_pop} : {1'b0, sum};
    push_tot = push_src + {16'd0, cmd_q.amount};
    sum_after_push = push_tot[48] ? SumMax : push_tot[47:0];
  end

  assign cmd_ready_o = (state_q == StIdle) && !res_valid_q;
  assign take        = cmd_valid_i && cmd_ready_o;
  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  always_comb begin
    state_d  = state_q;
    res_d    = res_q;
    rd_en    = 1'b0;
    rd_addr  = {a, head};
    wr_en    = 1'b0;
    do_pop   = 1'b0;
    do_push  = 1'b0;
    do_clear = 1'b0;
    case (state_q)
      StIdle: begin
        if (take) state_d = StRead;
      end
      StRead: begin
        res_d = '0;
        state_d = StOut;
        case (cmd_q.op)
          OpRecord: begin
            if (cmd_q.has_limit) begin
              if (full) begin
                rd_en = 1'b1;
                state_d = StDecide;
              end else begin
                wr_en   = 1'b1;
                do_push = 1'b1;
              end
            end
          end
          OpCheck: begin
            if (!cmd_q.has_limit) begin
              res_d.allowed = 1'b1;
            end else if (!cmd_q.limit_zero) begin
              rd_en   = 1'b1;
              state_d = StPrune;
            end
          end
          OpClear: do_clear = 1'b1;
          default: ;
        endcase
      end
      StPrune: begin
        // Data for the current head is in rd_*_q.
        if (cnt != '0 && age > window_i) begin
          do_pop  = 1'b1;
          rd_en   = 1'b1;
          rd_addr = {a, head_inc};
        end else begin
          res_d.window_sum = sum;
          res_d.allowed    = ({9'd0, tot} <= {18'd0, limits_i[a*40 +: 40]});
          state_d = StOut;
        end
      end
      StDecide: begin
        // Full ring: replace the oldest entry.
        wr_en   = 1'b1;
        do_push = 1'b1;
        res_d.entry_dropped = 1'b1;
        state_d = StOut;
      end
      StOut: begin
        state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rd_time_q <= time_mem[rd_addr];
      rd_amt_q  <= amt_mem[rd_addr];
    end
    if (wr_en) begin
      time_mem[{a, wpos}] <= cmd_q.now;
      amt_mem[{a, wpos}]  <= cmd_q.amount;
    end
    if (take) cmd_q <= cmd_i;
    res_q <= res_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      res_valid_q <= 1'b0;
      for (int i = 0; i < MaxApps; i++) begin
        head_q[i]  <= '0;
        count_q[i] <= '0;
        sum_q[i]   <= '0;
      end
    end else begin
      state_q <= state_d;
      if (state_q == StOut) res_valid_q <= 1'b1;
      else if (res_valid_q && res_ready_i) res_valid_q <= 1'b0;
      if (do_clear) begin
        for (int i = 0; i < MaxApps; i++) begin
          head_q[i]  <= '0;
          count_q[i] <= '0;
          sum_q[i]   <= '0;
        end
      end
      if (do_pop) begin
        head_q[a]  <= head_inc;
        count_q[a] <= cnt - 1'b1;
        sum_q[a]   <= sum_after_pop;
      end
      if (do_push) begin
        sum_q[a] <= sum_after_push;
        if (full) head_q[a] <= head_inc;
        else count_q[a] <= cnt + 1'b1;
      end
    end
  end
endmodule

// ----- test/sliding_window_rate_limiter_checker.sv -----
module sliding_window_rate_limiter_checker #(
  parameter int unsigned NumApps     = swrl_pkg::NumAppsDef,
  parameter int unsigned RingEntries = swrl_pkg::RingEntriesDef
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  input  logic         s_axis_tready,
  input  logic [135:0] s_axis_tdata,
  input  logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  input  logic [55:0]  m_axis_tdata,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [5:0]   paddr,
  input  logic [63:0]  pwdata,
  input  logic         pready,
  output int           fail_count,
  output int           pending_count,
  output int           result_count
);
  timeunit 1ns;
  timeprecision 1ps;
  import swrl_pkg::*;

  // Shadow copy of the limiter's registers and windows.
  logic [31:0] win_len;
  logic [3:0]  lim_on;
  logic [39:0] lim_bytes [MaxApps];
  logic [31:0] slot_time [MaxApps][RingEntries];
  logic [32:0] slot_amt  [MaxApps][RingEntries];
  int unsigned head_q [MaxApps];
  int unsigned fill_q [MaxApps];
  logic [47:0] live_sum [MaxApps];

  result_t verdict_q[$];

  function automatic logic [47:0] add_clamped(logic [47:0] a, logic [32:0] b);
    logic [48:0] s;
    s = {1'b0, a} + {16'd0, b};
    return s[48] ? SumMax : s[47:0];
  endfunction

  function automatic void drop_oldest(int unsigned a);
    logic [32:0] amt;
    amt = slot_amt[a][head_q[a]];
    live_sum[a] = (live_sum[a] >= {15'd0, amt}) ? live_sum[a] - {15'd0, amt} : '0;
    head_q[a] = (head_q[a] + 1) % RingEntries;
    fill_q[a]--;
  endfunction

  function automatic result_t account_item(logic [135:0] d);
    result_t r;
    op_e op;
    int unsigned a;
    logic lim;
    logic [31:0] now;
    logic [32:0] amt;
    int unsigned pos;
    op = op_e'(d[1:0]);
    a = {30'd0, d[3:2]};
    now = d[35:4];
    amt = {1'b0, d[67:36]} + {1'b0, d[99:68]};
    lim = (a < NumApps) && lim_on[a];
    r = '0;
    case (op)
      OpRecord: begin
        if (lim) begin
          if (fill_q[a] >= RingEntries) begin
            drop_oldest(a);
            r.entry_dropped = 1'b1;
          end
          pos = (head_q[a] + fill_q[a]) % RingEntries;
          slot_time[a][pos] = now;
          slot_amt[a][pos] = amt;
          fill_q[a]++;
          live_sum[a] = add_clamped(live_sum[a], amt);
        end
      end
      OpCheck: begin
        if (!lim) begin
          r.allowed = 1'b1;
        end else if (lim_bytes[a] != 0) begin
          while (fill_q[a] != 0 && (now - slot_time[a][head_q[a]]) > win_len)
            drop_oldest(a);
          r.window_sum = live_sum[a];
          r.allowed = ({1'b0, live_sum[a]} + {17'd0, d[131:100]}) <=
                      {9'd0, lim_bytes[a]};
        end
      end
      OpClear: begin
        for (int i = 0; i < MaxApps; i++) begin
          head_q[i] = 0;
          fill_q[i] = 0;
          live_sum[i] = '0;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  assign pending_count = verdict_q.size();

  always_ff @(posedge clk_i or negedge rst_ni) begin
    result_t got, want;
    if (!rst_ni) begin
      win_len <= WindowReset;
      lim_on <= '0;
      for (int i = 0; i < MaxApps; i++) begin
        lim_bytes[i] = '0;
        head_q[i] = 0;
        fill_q[i] = 0;
        live_sum[i] = '0;
      end
      verdict_q.delete();
      fail_count <= 0;
      result_count <= 0;
    end else begin
      // Register writes land at the access phase of an APB write.
      if (psel && penable && pwrite && pready) begin
        case (paddr[5:3])
          RegWindow: win_len <= pwdata[31:0];
          RegEnable: lim_on <= pwdata[3:0];
          RegLimit0, RegLimit1, RegLimit2, RegLimit3:
            lim_bytes[2'(paddr[5:3] - RegLimit0)] = pwdata[39:0];
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready)
        verdict_q.insert(verdict_q.size(), account_item(s_axis_tdata));
      if (m_axis_tvalid && m_axis_tready) begin
        got.allowed       = m_axis_tdata[0];
        got.window_sum    = m_axis_tdata[48:1];
        got.entry_dropped = m_axis_tdata[49];
        result_count <= result_count + 1;
        if (verdict_q.size() == 0) begin
          fail_count <= fail_count + 1;
          if (fail_count < 10)
            $display("ERROR: unexpected result %h", got);
        end else begin
          want = verdict_q.pop_front();
          if (got.allowed !== want.allowed || got.window_sum !== want.window_sum ||
              got.entry_dropped !== want.entry_dropped) begin
            fail_count <= fail_count + 1;
            if (fail_count < 10)
              $display("ERROR: result allowed/sum/dropped got %b/%0d/%b exp %b/%0d/%b",
                       got.allowed, got.window_sum, got.entry_dropped,
                       want.allowed, want.window_sum, want.entry_dropped);
          end
        end
      end
    end
  end

endmodule

// ----- test/sliding_window_rate_limiter_tb.sv -----
module sliding_window_rate_limiter_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import swrl_pkg::*;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  // tdata: operation, app_index, now_ticks, bytes_sent, bytes_received,
  // request_bytes, from the lowest bit up
  logic [135:0] s_axis_tdata = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  // tdata: allowed, window_sum, entry_dropped, from the lowest bit up
  logic [55:0]  m_axis_tdata;
  logic         psel = 1'b0;
  logic         penable = 1'b0;
  logic         pwrite = 1'b0;
  logic [5:0]   paddr = '0;
  logic [63:0]  pwdata = '0;
  logic [63:0]  prdata;
  logic         pready;

  int fail_count, pending_count, result_count;
  int sent_items;
  // While set, the result side holds m_axis_tready low for a long stretch.
  bit hold_results = 1'b0;
  // Current time base for the random traffic; it creeps forward and wraps.
  logic [31:0] clock_ticks = 32'hFFFF_F000;

  always #6 clk_i = ~clk_i;

  sliding_window_rate_limiter u_top (.*);

  sliding_window_rate_limiter_checker u_chk (.*);

  // Writes one register through a setup and an access phase. Registers
  // exceed 32 bits, so they sit at 8-byte strides.
  task automatic reg_write(logic [2:0] idx, logic [63:0] val);
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 3'b000};
    pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // Sends one transaction, with a random gap before it. Valid drops only
  // when a gap follows, so it is never lowered and raised in one step.
  task automatic send_item(op_e op, logic [1:0] app, logic [31:0] now,
                           logic [31:0] tx, logic [31:0] rx, logic [31:0] req);
    int gap;
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {4'd0, req, rx, tx, now, app, op};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    sent_items++;
  endtask

  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending_count != 0) @(posedge clk_i);
    // Leave time for the back end to settle before the next register write.
    repeat (20) @(posedge clk_i);
  endtask

  // A random limit, biased toward values near the traffic volume so that
  // both verdicts show up, with occasional extremes.
  function automatic logic [63:0] pick_limit();
    case ($urandom_range(0, 5))
      0: return 64'd0;
      1: return 64'hFF_FFFF_FFFF;
      2: return {24'd0, 8'($urandom), $urandom};
      default: return 64'($urandom_range(1, 32'h3FFF_FFFF)) << $urandom_range(0, 3);
    endcase
  endfunction

  // A random item. Most are records and checks on random applications with
  // timestamps that mostly advance slowly, so rings fill, wrap and expire.
  task automatic random_item();
    op_e op;
    logic [31:0] tx, rx;
    int r;
    r = $urandom_range(0, 99);
    op = (r < 50) ? OpRecord : (r < 94) ? OpCheck : (r < 97) ? OpClear : OpNone;
    clock_ticks += $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 300000);
    tx = ($urandom_range(0, 7) == 0) ? $urandom : $urandom_range(0, 32'h0FFF_FFFF);
    rx = ($urandom_range(0, 7) == 0) ? $urandom : $urandom_range(0, 32'h0FFF_FFFF);
    send_item(op, 2'($urandom), clock_ticks, tx, rx,
              ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 32'h1FFF_FFFF));
  endtask

  // Result side: random stalls, a stretch of full speed, and a long
  // hold-off on request.
  initial begin
    int wait_cycles;
    forever begin
      @(posedge clk_i);
      if (hold_results) begin
        m_axis_tready <= 1'b0;
      end else begin
        wait_cycles = (result_count > 300 && result_count < 500) ? 0 :
                      $urandom_range(0, 14);
        if (wait_cycles > 0) begin
          m_axis_tready <= 1'b0;
          repeat (wait_cycles) @(posedge clk_i);
        end
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Long receiver stall, counted in its own process.
  initial begin
    wait (sent_items >= 600);
    hold_results = 1'b1;
    repeat (400) @(posedge clk_i);
    hold_results = 1'b0;
  end

  initial begin
    #50ms;
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Directed: defaults first (no limit enabled, every check allowed).
    send_item(OpCheck, 2'd0, 32'd0, '0, '0, 32'hFFFF_FFFF);
    send_item(OpRecord, 2'd3, 32'd5, 32'hFFFF_FFFF, 32'hFFFF_FFFF, '0);
    send_item(OpNone, 2'd1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    drain_results();
    reg_write(RegWindow, 64'd100);
    reg_write(RegEnable, 64'hF);
    reg_write(RegLimit0, 64'hFF_FFFF_FFFF);
    reg_write(RegLimit1, 64'd0);
    reg_write(RegLimit2, 64'd1000);
    reg_write(RegLimit3, 64'd50);
    // Overfill app 0 with maximum amounts so the ring wraps and drops.
    for (int i = 0; i < 18; i++)
      send_item(OpRecord, 2'd0, 32'hFFFF_FFF0 + i, 32'hFFFF_FFFF, 32'hFFFF_FFFF, '0);
    // Check across the timestamp wrap, some entries expire.
    send_item(OpCheck, 2'd0, 32'd100, '0, '0, 32'hFFFF_FFFF);
    send_item(OpCheck, 2'd1, 32'd0, '0, '0, '0);        // zero limit refuses
    send_item(OpRecord, 2'd2, 32'd10, 32'd500, 32'd500, '0);
    send_item(OpCheck, 2'd2, 32'd20, '0, '0, 32'd0);    // exactly at limit
    send_item(OpCheck, 2'd2, 32'd20, '0, '0, 32'd1);
    send_item(OpClear, 2'd0, '0, '0, '0, '0);
    send_item(OpCheck, 2'd0, 32'd200, '0, '0, 32'd5);
    drain_results();

    // Random phases, each with new settings; extremes of the window too.
    for (int ph = 0; ph < 8; ph++) begin
      reg_write(RegWindow, ph == 0 ? 64'd1 : ph == 1 ? 64'hFFFF_FFFF :
                64'($urandom_range(1, 2000000)));
      reg_write(RegEnable, ph == 2 ? 64'd0 : ph == 3 ? 64'hF : 64'($urandom_range(0, 15)));
      for (int a = 0; a < MaxApps; a++)
        reg_write(3'(RegLimit0 + a), pick_limit());
      for (int i = 0; i < 180; i++)
        random_item();
      drain_results();
    end

    $display("Sent %0d items through 8 random settings plus directed cases,", sent_items);
    $display("with ring wrap, expiry, clears, zero limits and a long output stall.");
    if (fail_count == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule
